>>> sv/usb_ethernet_frame_reassembly_ring_macros.svh
// Assertion macros for the frame reassembly ring.
// Defining NO_ASSERTIONS leaves every macro with an empty body.
`ifndef USB_ETHERNET_FRAME_REASSEMBLY_RING_MACROS_SVH
`define USB_ETHERNET_FRAME_REASSEMBLY_RING_MACROS_SVH

`ifndef NO_ASSERTIONS

// Implication in the same cycle, sampled on the rising edge of clk.
`define UFR_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Implication checked in the next cycle.
`define UFR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define UFR_ASSERT_IMP(lbl, ante, cons, msg)
`define UFR_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

>>> sv/ufr_pkg.sv
// Shared types and constants of the frame reassembly ring.
// No dependencies; imported by the front end, the back end and the top level.
package ufr_pkg;

	localparam int unsigned FLEN_W = 9;
	localparam int unsigned CNT_W  = 3;

	localparam int unsigned HDR_BYTES   = 14;
	localparam int unsigned OFF_TYPE_HI = 12;
	localparam int unsigned OFF_TYPE_LO = 13;
	localparam int unsigned OFF_LEN_HI  = 16;
	localparam int unsigned OFF_LEN_LO  = 17;

	localparam logic [15:0] ETYPE_IPV4 = 16'h0800;

	typedef enum logic [2:0] {
		ST_TAKEN     = 3'd0,
		ST_PARTIAL   = 3'd1,
		ST_DONE      = 3'd2,
		ST_RUNT      = 3'd3,
		ST_FULL_DROP = 3'd4,
		ST_OVERSIZE  = 3'd5,
		ST_READ      = 3'd6,
		ST_EMPTY     = 3'd7
	} status_t;

	typedef struct packed {
		status_t           status;
		logic              last;
		logic [FLEN_W-1:0] flen;
		logic [CNT_W-1:0]  stored;
	} res_t;

endpackage

>>> sv/ufr_front.sv
// Front end: accepts words, keeps ring and frame state, and emits per word one
// store write, read or no access with its result fields. Depends on ufr_pkg.
module ufr_front import ufr_pkg::*; #(
	parameter int unsigned FRAME_BYTES = 512,
	parameter int unsigned RING_SLOTS  = 8,
	parameter int unsigned AW          = $clog2(RING_SLOTS * FRAME_BYTES)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          accept,
	input  logic          cmd,
	input  logic [7:0]    usb_byte,
	input  logic          usb_packet_end,
	output res_t          op_res,
	output logic          op_we,
	output logic          op_re,
	output logic [AW-1:0] op_addr,
	output logic [7:0]    op_wdata
);

	localparam int unsigned SW = $clog2(RING_SLOTS);
	localparam int unsigned BW = $clog2(FRAME_BYTES + 1);
	localparam int unsigned LW = $clog2(FRAME_BYTES);
	localparam logic [AW-1:0] FB_A  = AW'(FRAME_BYTES);
	localparam logic [BW-1:0] FB_B  = BW'(FRAME_BYTES);
	localparam logic [LW:0]   FB_L  = (LW + 1)'(FRAME_BYTES);
	localparam logic [SW:0]   RS_W  = (SW + 1)'(RING_SLOTS);
	localparam logic [SW-1:0] LAST_SLOT = SW'(RING_SLOTS - 1);

	logic [SW-1:0] ws_q, rs_q, ws_n, rs_n;
	logic          open_q, open_n, drop_q, drop_n;
	logic [BW-1:0] br_q, br_n, br_eff;
	logic [15:0]   exp_q, exp_n, exp_eff;
	logic [15:0]   et_q, et_n, ip_q, ip_n;
	logic [LW-1:0] ro_q, ro_n;
	logic [LW-1:0] slot_len_q [RING_SLOTS];
	logic          len_we;
	logic [16:0]   ip_sum;
	logic [LW:0]   ro_inc;
	logic [LW-1:0] rd_len;
	logic [SW:0]   diff;
	status_t       st;
	logic          last;
	logic [FLEN_W-1:0] flen;

	function automatic logic [SW-1:0] next_slot(input logic [SW-1:0] s);
		return (s == LAST_SLOT) ? '0 : s + SW'(1);
	endfunction

	always_comb begin
		ws_n    = ws_q;
		rs_n    = rs_q;
		open_n  = open_q;
		drop_n  = drop_q;
		ro_n    = ro_q;
		len_we  = 1'b0;
		op_we   = 1'b0;
		op_re   = 1'b0;
		op_addr = '0;
		st      = ST_TAKEN;
		last    = 1'b0;
		flen    = '0;
		// A frame starting with this word sees cleared counters and captures.
		br_eff  = open_q ? br_q  : '0;
		exp_eff = open_q ? exp_q : '0;
		et_n    = open_q ? et_q  : '0;
		ip_n    = open_q ? ip_q  : '0;
		br_n    = br_q;
		exp_n   = exp_q;
		ip_sum  = '0;
		rd_len  = slot_len_q[rs_q];
		ro_inc  = {1'b0, ro_q} + (LW + 1)'(1);
		if (!cmd) begin
			if (drop_q) begin
				st = ST_FULL_DROP;
				if (usb_packet_end)
					drop_n = 1'b0;
			end else if (!open_q && next_slot(ws_q) == rs_q) begin
				st = ST_FULL_DROP;
				if (!usb_packet_end)
					drop_n = 1'b1;
			end else begin
				open_n = 1'b1;
				br_n   = br_eff;
				exp_n  = exp_eff;
				if (br_eff < FB_B) begin
					op_we   = 1'b1;
					op_addr = AW'(ws_q) * FB_A + AW'(br_eff);
					if (br_eff == BW'(OFF_TYPE_HI)) et_n[15:8] = usb_byte;
					if (br_eff == BW'(OFF_TYPE_LO)) et_n[7:0]  = usb_byte;
					if (br_eff == BW'(OFF_LEN_HI))  ip_n[15:8] = usb_byte;
					if (br_eff == BW'(OFF_LEN_LO))  ip_n[7:0]  = usb_byte;
					br_n = br_eff + BW'(1);
				end
				if (!usb_packet_end) begin
					st = ST_TAKEN;
				end else if (16'(br_n) < 16'(HDR_BYTES)) begin
					st   = ST_RUNT;
					br_n = '0;
				end else begin
					if (exp_eff == '0) begin
						ip_sum = {1'b0, ip_n} + 17'(HDR_BYTES);
						if (et_n == ETYPE_IPV4)
							exp_n = ip_sum[16] ? 16'hFFFF : ip_sum[15:0];
						else
							exp_n = 16'(br_n);
					end
					if (16'(br_n) < exp_n) begin
						st = ST_PARTIAL;
					end else begin
						open_n = 1'b0;
						if (br_n >= FB_B) begin
							st = ST_OVERSIZE;
						end else begin
							st     = ST_DONE;
							len_we = 1'b1;
							flen   = FLEN_W'(br_n);
							ws_n   = next_slot(ws_q);
						end
					end
				end
			end
		end else if (ws_q == rs_q) begin
			st = ST_EMPTY;
		end else begin
			st      = ST_READ;
			op_re   = 1'b1;
			op_addr = AW'(rs_q) * FB_A + AW'(ro_q);
			flen    = FLEN_W'(rd_len);
			ro_n    = ro_inc[LW-1:0];
			if (ro_inc >= {1'b0, rd_len} || ro_inc >= FB_L) begin
				last = 1'b1;
				ro_n = '0;
				rs_n = next_slot(rs_q);
			end
		end
		// Frames waiting after this word, modulo the ring size.
		diff = {1'b0, ws_n} - {1'b0, rs_n};
		if (ws_n < rs_n)
			diff = diff + RS_W;
		op_res.status = st;
		op_res.last   = last;
		op_res.flen   = flen;
		op_res.stored = CNT_W'(diff);
		op_wdata      = usb_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ws_q   <= '0;
			rs_q   <= '0;
			open_q <= 1'b0;
			drop_q <= 1'b0;
			br_q   <= '0;
			exp_q  <= '0;
			et_q   <= '0;
			ip_q   <= '0;
			ro_q   <= '0;
			for (int i = 0; i < RING_SLOTS; i++)
				slot_len_q[i] <= '0;
		end else if (accept) begin
			ws_q   <= ws_n;
			rs_q   <= rs_n;
			open_q <= open_n;
			drop_q <= drop_n;
			br_q   <= br_n;
			exp_q  <= exp_n;
			et_q   <= et_n;
			ip_q   <= ip_n;
			ro_q   <= ro_n;
			if (len_we)
				slot_len_q[ws_q] <= br_n[LW-1:0];
		end
	end

endmodule

>>> sv/ufr_queue.sv
// Short first-in first-out queue that decouples the front end from the back end.
// No dependencies.
module ufr_queue #(
	parameter int unsigned W     = 32,
	parameter int unsigned DEPTH = 4
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] push_data,
	input  logic         pop,
	output logic [W-1:0] pop_data,
	output logic         full,
	output logic         empty
);

	localparam int unsigned PW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

	logic [W-1:0]  slots_q [DEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [CW-1:0] count_q;

	assign full     = (count_q == CW'(DEPTH));
	assign empty    = (count_q == '0);
	assign pop_data = slots_q[rd_q];

	always_ff @(posedge clk) begin
		if (push)
			slots_q[wr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push)
				wr_q <= (wr_q == LAST_PTR) ? '0 : wr_q + PW'(1);
			if (pop)
				rd_q <= (rd_q == LAST_PTR) ? '0 : rd_q + PW'(1);
			if (push && !pop)
				count_q <= count_q + CW'(1);
			else if (pop && !push)
				count_q <= count_q - CW'(1);
		end
	end

endmodule

>>> sv/ufr_back.sv
// Back end: holds the frame store, carries out each queued write or read and
// registers the result word. Depends on ufr_pkg.
module ufr_back import ufr_pkg::*; #(
	parameter int unsigned FRAME_BYTES = 512,
	parameter int unsigned RING_SLOTS  = 8,
	parameter int unsigned AW          = $clog2(RING_SLOTS * FRAME_BYTES)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          op_valid,
	output logic          op_pop,
	input  res_t          op_res,
	input  logic          op_we,
	input  logic          op_re,
	input  logic [AW-1:0] op_addr,
	input  logic [7:0]    op_wdata,
	output logic          out_valid,
	input  logic          out_ready,
	output res_t          out_res,
	output logic [7:0]    out_data
);

	localparam int unsigned DEPTH = RING_SLOTS * FRAME_BYTES;

	logic [7:0] store [DEPTH];
	logic [7:0] rdata_q;
	logic       is_rd_q;
	logic       valid_q;
	res_t       res_q;

	// The output register frees up as its word is taken, so a new one may enter.
	assign op_pop    = op_valid && (!valid_q || out_ready);
	assign out_valid = valid_q;
	assign out_res   = res_q;
	assign out_data  = is_rd_q ? rdata_q : 8'h00;

	always_ff @(posedge clk) begin
		if (op_pop && op_we)
			store[op_addr] <= op_wdata;
		if (op_pop && op_re)
			rdata_q <= store[op_addr];
	end

	always_ff @(posedge clk) begin
		if (op_pop) begin
			res_q   <= op_res;
			is_rd_q <= op_re;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (op_pop)
			valid_q <= 1'b1;
		else if (out_ready)
			valid_q <= 1'b0;
	end

endmodule

>>> sv/usb_ethernet_frame_reassembly_ring.sv
// An accepted word is queued and then moved into the back end's output register once that
// register is free. Throughput: one word per cycle while the queue has room and the output
// is taken, set by the single store access per word in the back end; a four-entry queue
// lets input and output stall independently.
// Reset (arst_n, asynchronous) clears the ring pointers, frame state and slot
// lengths at once; the frame store is not cleared and needs no clearing pass.
module usb_ethernet_frame_reassembly_ring import ufr_pkg::*; #(
	parameter int unsigned FRAME_BYTES = 512,
	parameter int unsigned RING_SLOTS  = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              cmd,
	input  logic [7:0]        usb_byte,
	input  logic              usb_packet_end,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [2:0]        status,
	output logic [7:0]        read_data,
	output logic              read_last,
	output logic [FLEN_W-1:0] frame_length,
	output logic [CNT_W-1:0]  frames_stored
);

	localparam int unsigned AW = $clog2(RING_SLOTS * FRAME_BYTES);
	localparam int unsigned QW = $bits(res_t) + 2 + AW + 8;

	res_t          f_res, b_res, out_res;
	logic          f_we, f_re, b_we, b_re;
	logic [AW-1:0] f_addr, b_addr;
	logic [7:0]    f_wdata, b_wdata;
	logic          q_push, q_pop, q_full, q_empty;
	logic [QW-1:0] q_in, q_out;

	assign in_ready = !q_full;
	assign q_push   = in_valid && in_ready;
	assign q_in     = {f_res, f_we, f_re, f_addr, f_wdata};
	assign {b_res, b_we, b_re, b_addr, b_wdata} = q_out;

	ufr_front #(
		.FRAME_BYTES(FRAME_BYTES),
		.RING_SLOTS (RING_SLOTS),
		.AW         (AW)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (q_push),
		.cmd           (cmd),
		.usb_byte      (usb_byte),
		.usb_packet_end(usb_packet_end),
		.op_res        (f_res),
		.op_we         (f_we),
		.op_re         (f_re),
		.op_addr       (f_addr),
		.op_wdata      (f_wdata)
	);

	ufr_queue #(
		.W    (QW),
		.DEPTH(4)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_data(q_in),
		.pop      (q_pop),
		.pop_data (q_out),
		.full     (q_full),
		.empty    (q_empty)
	);

	ufr_back #(
		.FRAME_BYTES(FRAME_BYTES),
		.RING_SLOTS (RING_SLOTS),
		.AW         (AW)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.op_valid (!q_empty),
		.op_pop   (q_pop),
		.op_res   (b_res),
		.op_we    (b_we),
		.op_re    (b_re),
		.op_addr  (b_addr),
		.op_wdata (b_wdata),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_res  (out_res),
		.out_data (read_data)
	);

	assign status        = out_res.status;
	assign read_last     = out_res.last;
	assign frame_length  = out_res.flen;
	assign frames_stored = out_res.stored;

`include "usb_ethernet_frame_reassembly_ring_macros.svh"

	`UFR_ASSERT_IMP(a_queue_no_pop_empty, q_empty, !q_pop, "queue popped while empty")
	`UFR_ASSERT_NEXT(a_queue_fills, q_push && !q_pop && !q_empty && !q_full, !q_empty,
		"queue lost its words after a push")
	`UFR_ASSERT_IMP(a_single_access, q_pop, !(b_we && b_re), "store written and read at once")

endmodule
